// File: rtl/occupancy_grid_block_or_downsampler_macros.svh
// Assertion macros shared by the downsampler RTL.
`ifndef OCCUPANCY_GRID_BLOCK_OR_DOWNSAMPLER_MACROS_SVH
`define OCCUPANCY_GRID_BLOCK_OR_DOWNSAMPLER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define OGD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define OGD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ogd_pkg.sv
// Types and constants of the occupancy grid downsampler.
`timescale 1ns / 1ps
package ogd_pkg;

  localparam int BS_W    = 5;   // block size register width
  localparam int SIZE_W  = 13;  // fine map size register width
  localparam int CNT_W   = 12;  // fine and coarse counter width
  localparam int BLK_W   = 4;   // in-block counter width
  localparam int ADDR_W  = 4;   // APB address width
  localparam int DATA_W  = 32;  // APB data width

  localparam logic [BS_W-1:0]   BS_MAX   = 5'd16;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

  // Register index within the APB map, byte address / 4.
  typedef enum logic [1:0] {
    REG_BLOCK_SIZE  = 2'd0,
    REG_FINE_WIDTH  = 2'd1,
    REG_FINE_HEIGHT = 2'd2
  } ogd_reg_t;

  // Status of an iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } ogd_div_stat_t;

endpackage

// File: rtl/ogd_in_if.sv
// Input channel: one fine occupancy bit per item.
`timescale 1ns / 1ps
interface ogd_in_if;
  logic valid;
  logic ready;
  logic occupied;

  modport source (output valid, output occupied, input ready);
  modport sink   (input valid, input occupied, output ready);
endinterface

// File: rtl/ogd_out_if.sv
// Output channel: one coarse cell with its position per item.
`timescale 1ns / 1ps
interface ogd_out_if;
  logic        valid;
  logic        ready;
  logic        coarse_occupied;
  logic [11:0] coarse_row;
  logic [11:0] coarse_col;
  logic        last_cell;

  modport source (output valid, output coarse_occupied, output coarse_row,
                  output coarse_col, output last_cell, input ready);
  modport sink   (input valid, input coarse_occupied, input coarse_row,
                  input coarse_col, input last_cell, output ready);
endinterface

// File: rtl/ogd_div.sv
// Restoring divider, one quotient bit per cycle, map size by block size.
`timescale 1ns / 1ps
module ogd_div
  import ogd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SIZE_W-1:0] dividend,
  input  logic [BS_W-1:0]   divisor,
  output logic [SIZE_W-1:0] quotient,
  output ogd_div_stat_t     stat
);

  localparam int STEP_W = $clog2(SIZE_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SIZE_W - 1);

  logic [SIZE_W-1:0] dvd;
  logic [BS_W-1:0]   rem;
  logic [BS_W-1:0]   dsr;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [BS_W:0]     trial;
  logic              fits;

  // Shift the next dividend bit into the remainder and test it.
  always_comb begin
    trial = {rem, dvd[SIZE_W-1]};
    fits  = trial >= {1'b0, dsr};
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[SIZE_W-2:0], 1'b0};
      quotient <= {quotient[SIZE_W-2:0], fits};
      rem      <= fits ? BS_W'(trial - {1'b0, dsr}) : trial[BS_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/occupancy_grid_block_or_downsampler.sv
// Top level of the occupancy grid block-OR downsampler.
//
// Usage: fine occupancy bits enter on in_ch, one per item, in raster order.
// Each bit is ORed into its block_size x block_size coarse cell; the partial
// OR of each coarse column lives in a one-bit row memory. When the
// bottom-right fine cell of a block arrives, the coarse cell leaves on
// out_ch with its row, column and a last_cell flag. Fine cells in the strip
// beyond the last full block are consumed and dropped.
// Throughput: one item per cycle when not stalled or reconfiguring, set by
// the row memory's single read-modify-write per item; a same-entry write is
// forwarded to the read. Stage two registers each item and the output
// register its result. Stall: a result waiting in the output register holds;
// items that close no block keep flowing, and the next item that closes a
// block waits in the second stage while in_ch.ready stays low.
// Configuration: after any APB write the coarse counts per axis are
// recomputed by two serial dividers; in_ch.ready stays low while they run.
// Reset: counters clear, registers take block 1 and a 4096 x 4096 map; the
// row memory is not cleared, each block's first fine cell overwrites it.
`timescale 1ns / 1ps
`include "occupancy_grid_block_or_downsampler_macros.svh"
module occupancy_grid_block_or_downsampler
  import ogd_pkg::*;
#(
  parameter int MAX_COARSE_COLS = 4096
) (
  input  logic              clk,
  input  logic              rst,
  ogd_in_if.sink            in_ch,
  ogd_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int DEPTH = (MAX_COARSE_COLS < 4096) ? MAX_COARSE_COLS : 4096;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [SIZE_W-1:0] COL_CAP = SIZE_W'(DEPTH);

  // Configuration registers and their clamped values.
  logic [BS_W-1:0]   reg_block_size;
  logic [SIZE_W-1:0] reg_fine_width;
  logic [SIZE_W-1:0] reg_fine_height;
  logic [BS_W-1:0]   bs_c;
  logic [SIZE_W-1:0] w_c;
  logic [SIZE_W-1:0] h_c;
  logic [BLK_W-1:0]  bs_m1;
  logic [CNT_W-1:0]  w_m1;
  logic [CNT_W-1:0]  h_m1;
  logic              cfg_wr;
  ogd_reg_t          cfg_idx;

  // Coarse counts per axis and divider control.
  logic [SIZE_W-1:0] ncols;
  logic [SIZE_W-1:0] nrows;
  logic [SIZE_W-1:0] q_cols;
  logic [SIZE_W-1:0] q_rows;
  ogd_div_stat_t     col_stat;
  ogd_div_stat_t     row_stat;
  logic              div_start;
  logic              cfg_busy;

  // Raster counters.
  logic [CNT_W-1:0]  fine_col_count;
  logic [CNT_W-1:0]  fine_row_count;
  logic [BLK_W-1:0]  in_block_col;
  logic [BLK_W-1:0]  in_block_row;
  logic [CNT_W-1:0]  coarse_col_count;
  logic [CNT_W-1:0]  coarse_row_count;

  // Row memory.
  logic              row_mem [DEPTH];
  logic              mem_rdata;
  logic              mem_we;
  logic [AW-1:0]     rd_addr;

  // Second stage.
  logic              s1_valid;
  logic              s1_active;
  logic              s1_first;
  logic              s1_emit;
  logic              s1_last;
  logic              s1_occ;
  logic              s1_fwd;
  logic              s1_fwd_val;
  logic [AW-1:0]     s1_addr;
  logic [CNT_W-1:0]  s1_row;
  logic [CNT_W-1:0]  s1_col;
  logic              s1_acc;
  logic              adv1;

  // First stage decisions.
  logic              in_acc;
  logic              active;
  logic              first;
  logic              corner;
  logic              last;
  logic              fwd;

  // Output register.
  logic              out_valid;

  // Clamp the registers into their legal ranges.
  always_comb begin
    if (reg_block_size == '0)        bs_c = BS_W'(1);
    else if (reg_block_size > BS_MAX) bs_c = BS_MAX;
    else                              bs_c = reg_block_size;
    if (reg_fine_width == '0)          w_c = SIZE_W'(1);
    else if (reg_fine_width > SIZE_MAX) w_c = SIZE_MAX;
    else                                w_c = reg_fine_width;
    if (reg_fine_height == '0)          h_c = SIZE_W'(1);
    else if (reg_fine_height > SIZE_MAX) h_c = SIZE_MAX;
    else                                 h_c = reg_fine_height;
    bs_m1 = BLK_W'(bs_c - BS_W'(1));
    w_m1  = CNT_W'(w_c - SIZE_W'(1));
    h_m1  = CNT_W'(h_c - SIZE_W'(1));
  end

  // APB port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = ogd_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_block_size  <= BS_W'(1);
      reg_fine_width  <= SIZE_MAX;
      reg_fine_height <= SIZE_MAX;
      div_start       <= 1'b0;
    end else begin
      div_start <= cfg_wr;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_BLOCK_SIZE:  reg_block_size  <= pwdata[BS_W-1:0];
          REG_FINE_WIDTH:  reg_fine_width  <= pwdata[SIZE_W-1:0];
          REG_FINE_HEIGHT: reg_fine_height <= pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BLOCK_SIZE:  prdata = DATA_W'(reg_block_size);
      REG_FINE_WIDTH:  prdata = DATA_W'(reg_fine_width);
      REG_FINE_HEIGHT: prdata = DATA_W'(reg_fine_height);
      default:         prdata = '0;
    endcase
  end

  // Recompute the coarse counts after a register write.
  ogd_div u_div_cols (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (w_c),
    .divisor  (bs_c),
    .quotient (q_cols),
    .stat     (col_stat)
  );

  ogd_div u_div_rows (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (h_c),
    .divisor  (bs_c),
    .quotient (q_rows),
    .stat     (row_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ncols <= COL_CAP;
      nrows <= SIZE_MAX;
    end else begin
      if (col_stat.done) ncols <= (q_cols > COL_CAP) ? COL_CAP : q_cols;
      if (row_stat.done) nrows <= q_rows;
    end
  end

  assign cfg_busy = div_start | col_stat.busy | col_stat.done |
                    row_stat.busy | row_stat.done;

  // Handshake: the second stage moves on when its result, if any, has room.
  assign adv1        = s1_valid & (~s1_emit | ~out_valid | out_ch.ready);
  assign in_ch.ready = ~cfg_busy & (~s1_valid | adv1);
  assign in_acc      = in_ch.valid & in_ch.ready;

  // Classify the incoming item from the counters.
  always_comb begin
    active  = ({1'b0, coarse_col_count} < ncols) && ({1'b0, coarse_row_count} < nrows);
    first   = (in_block_row == '0) && (in_block_col == '0);
    corner  = (in_block_row >= bs_m1) && (in_block_col >= bs_m1);
    last    = ({1'b0, coarse_row_count} == nrows - SIZE_W'(1)) &&
              ({1'b0, coarse_col_count} == ncols - SIZE_W'(1));
    rd_addr = coarse_col_count[AW-1:0];
    fwd     = adv1 & s1_active & (s1_addr == rd_addr);
  end

  // Advance the raster counters on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_col_count   <= '0;
      fine_row_count   <= '0;
      in_block_col     <= '0;
      in_block_row     <= '0;
      coarse_col_count <= '0;
      coarse_row_count <= '0;
    end else if (in_acc) begin
      if (fine_col_count >= w_m1) begin
        fine_col_count   <= '0;
        in_block_col     <= '0;
        coarse_col_count <= '0;
        if (fine_row_count >= h_m1) begin
          fine_row_count   <= '0;
          in_block_row     <= '0;
          coarse_row_count <= '0;
        end else begin
          fine_row_count <= fine_row_count + 1'b1;
          if (in_block_row >= bs_m1) begin
            in_block_row     <= '0;
            coarse_row_count <= coarse_row_count + 1'b1;
          end else begin
            in_block_row <= in_block_row + 1'b1;
          end
        end
      end else begin
        fine_col_count <= fine_col_count + 1'b1;
        if (in_block_col >= bs_m1) begin
          in_block_col     <= '0;
          coarse_col_count <= coarse_col_count + 1'b1;
        end else begin
          in_block_col <= in_block_col + 1'b1;
        end
      end
    end
  end

  // Second stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (adv1) begin
      s1_valid <= 1'b0;
    end
  end

  // Second stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_active  <= active;
      s1_first   <= first;
      s1_emit    <= active & corner;
      s1_last    <= last;
      s1_occ     <= in_ch.occupied;
      s1_fwd     <= fwd;
      s1_fwd_val <= s1_acc;
      s1_addr    <= rd_addr;
      s1_row     <= coarse_row_count;
      s1_col     <= coarse_col_count;
    end
  end

  // Merge the stored partial OR with the new bit.
  always_comb begin
    if (s1_first) s1_acc = s1_occ;
    else          s1_acc = (s1_fwd ? s1_fwd_val : mem_rdata) | s1_occ;
  end

  assign mem_we = adv1 & s1_active;

  // Row memory: read on accept, write back as an active item leaves stage two.
  always_ff @(posedge clk) begin
    if (mem_we) row_mem[s1_addr] <= s1_acc;
    if (in_acc) mem_rdata <= row_mem[rd_addr];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv1 & s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 & s1_emit) begin
      out_ch.coarse_occupied <= s1_acc;
      out_ch.coarse_row      <= s1_row;
      out_ch.coarse_col      <= s1_col;
      out_ch.last_cell       <= s1_last;
    end
  end

  assign out_ch.valid = out_valid;

  // Checks.
  `OGD_ASSERT_NXT(a_cfg_blocks_input, clk, rst, cfg_wr, !in_acc,
    "item accepted before coarse counts were recomputed")
  `OGD_ASSERT_NXT(a_s1_hold, clk, rst, s1_valid && !adv1,
    s1_valid && $stable(s1_addr) && $stable(s1_occ), "stalled stage two item changed")
  `OGD_ASSERT_IMP(a_ncols_cap, clk, rst, 1'b1, ncols <= COL_CAP,
    "coarse column count beyond row memory depth")

endmodule

// File: dv/occupancy_grid_block_or_downsampler_tb.sv
// Self-checking testbench: raster occupancy stream in, block-OR coarse cells checked out.
`timescale 1ns / 1ps
module occupancy_grid_block_or_downsampler_tb
  import ogd_pkg::*;
();

  localparam int COL_LIMIT    = 4096;
  localparam int DRAIN_CYCLES = 4;    // output register latency plus the stall slot
  localparam int HOLD_CYCLES  = 300;  // long output hold that backs up the input
  localparam int HOLD_AT      = 100;  // coarse cells checked before the long hold

  // One coarse cell, laid out in port order
  typedef struct packed {
    logic        occupied;
    logic [11:0] row;
    logic [11:0] col;
    logic        last_cell;
  } coarse_cell_t;

  typedef enum bit {PLAN_CELL, PLAN_WRITE} plan_kind_t;

  // One line of the directed plan: a fine cell or a register write
  typedef struct {
    plan_kind_t   kind;
    ogd_reg_t     reg_idx;
    logic [31:0]  word;
    bit           occ;
    bit           typed;
    bit           typed_emits;
    coarse_cell_t typed_cell;
  } plan_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ogd_in_if  in_ch ();
  ogd_out_if out_ch ();

  occupancy_grid_block_or_downsampler #(
    .MAX_COARSE_COLS(COL_LIMIT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copies as written, before clamping
  logic [BS_W-1:0]   cfg_block  = 5'd1;
  logic [SIZE_W-1:0] cfg_width  = 13'd4096;
  logic [SIZE_W-1:0] cfg_height = 13'd4096;

  // Raster position and the per-column running OR
  logic [CNT_W-1:0] fine_col = '0;
  logic [CNT_W-1:0] fine_row = '0;
  logic [BLK_W-1:0] blk_col  = '0;
  logic [BLK_W-1:0] blk_row  = '0;
  logic [CNT_W-1:0] crs_col  = '0;
  logic [CNT_W-1:0] crs_row  = '0;
  bit               col_or [COL_LIMIT];

  coarse_cell_t expected_cells [$];
  int cells_sent    = 0;
  int cells_checked = 0;
  int reg_writes    = 0;
  int failures      = 0;
  bit quiet         = 0;

  plan_row_t directed_plan [$];

  // Fold one fine cell into its block; report the coarse cell if the block closes
  task automatic fold_fine_cell(input bit occ, output bit emits, output coarse_cell_t coarse);
    int unsigned bs;
    int unsigned w;
    int unsigned h;
    int unsigned ncols;
    int unsigned nrows;
    int unsigned idx;
    bit acc;
    bs = (cfg_block == 0) ? 1 : (cfg_block > 16) ? 16 : cfg_block;
    w  = (cfg_width == 0) ? 1 : (cfg_width > 4096) ? 4096 : cfg_width;
    h  = (cfg_height == 0) ? 1 : (cfg_height > 4096) ? 4096 : cfg_height;
    ncols = w / bs;
    nrows = h / bs;
    if (ncols > COL_LIMIT) ncols = COL_LIMIT;
    emits  = 1'b0;
    coarse = '0;
    if (crs_col < ncols && crs_row < nrows) begin
      idx = crs_col % COL_LIMIT;
      // the block's first fine cell starts a fresh OR
      acc = (blk_row == 0 && blk_col == 0) ? occ : (col_or[idx] | occ);
      col_or[idx] = acc;
      if (blk_row >= bs - 1 && blk_col >= bs - 1) begin
        emits            = 1'b1;
        coarse.occupied  = acc;
        coarse.row       = crs_row;
        coarse.col       = crs_col;
        coarse.last_cell = (crs_row == nrows - 1 && crs_col == ncols - 1);
      end
    end
    // advance the raster position; limits use at-or-beyond so stale counters wrap
    if (fine_col >= w - 1) begin
      fine_col = '0;
      blk_col  = '0;
      crs_col  = '0;
      if (fine_row >= h - 1) begin
        fine_row = '0;
        blk_row  = '0;
        crs_row  = '0;
      end else begin
        fine_row = fine_row + 1'b1;
        if (blk_row >= bs - 1) begin
          blk_row = '0;
          crs_row = crs_row + 1'b1;
        end else begin
          blk_row = blk_row + 1'b1;
        end
      end
    end else begin
      fine_col = fine_col + 1'b1;
      if (blk_col >= bs - 1) begin
        blk_col = '0;
        crs_col = crs_col + 1'b1;
      end else begin
        blk_col = blk_col + 1'b1;
      end
    end
  endtask

  function automatic plan_row_t cell_row(bit occ);
    plan_row_t r;
    r.kind        = PLAN_CELL;
    r.reg_idx     = REG_BLOCK_SIZE;
    r.word        = '0;
    r.occ         = occ;
    r.typed       = 1'b0;
    r.typed_emits = 1'b0;
    r.typed_cell  = '0;
    return r;
  endfunction

  // Block size one: the cell comes straight out at the given position
  function automatic plan_row_t known_row(bit occ, int row, int col, bit last);
    plan_row_t r;
    r = cell_row(occ);
    r.typed                = 1'b1;
    r.typed_emits          = 1'b1;
    r.typed_cell.occupied  = occ;
    r.typed_cell.row       = row[11:0];
    r.typed_cell.col       = col[11:0];
    r.typed_cell.last_cell = last;
    return r;
  endfunction

  // Cell that closes no coarse cell
  function automatic plan_row_t none_row(bit occ);
    plan_row_t r;
    r = cell_row(occ);
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic plan_row_t reg_row(ogd_reg_t idx, logic [31:0] word);
    plan_row_t r;
    r = cell_row(1'b0);
    r.kind    = PLAN_WRITE;
    r.reg_idx = idx;
    r.word    = word;
    return r;
  endfunction

  // Offer one fine cell and hold it until accepted
  task automatic send_cell(input bit occ, input bit typed, input bit typed_emits,
                           input coarse_cell_t typed_cell);
    bit emits;
    coarse_cell_t coarse;
    fold_fine_cell(occ, emits, coarse);
    if (typed) begin
      emits  = typed_emits;
      coarse = typed_cell;
    end
    if (emits) expected_cells.push_back(coarse);
    if (!quiet && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.occupied <= occ;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    cells_sent++;
  endtask

  // Drop valid, wait out every pending coarse cell and the pipeline tail
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ogd_reg_t idx, input logic [31:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BLOCK_SIZE:  cfg_block  = word[BS_W-1:0];
      REG_FINE_WIDTH:  cfg_width  = word[SIZE_W-1:0];
      REG_FINE_HEIGHT: cfg_height = word[SIZE_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Reprogram all three registers, stream cells, stop only at the start of a coarse row
  task automatic run_phase(input logic [31:0] bs_word, input logic [31:0] w_word,
                           input logic [31:0] h_word, input int n, input int density,
                           input int pause_at);
    settle();
    write_reg(REG_BLOCK_SIZE, bs_word);
    write_reg(REG_FINE_WIDTH, w_word);
    write_reg(REG_FINE_HEIGHT, h_word);
    for (int i = 0; i < n || !(fine_col == 0 && blk_row == 0); i++) begin
      if (i == pause_at) begin
        // let the block drain completely before going on
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_cells.size() != 0);
      end
      send_cell($urandom_range(99) < density, 1'b0, 1'b0, '0);
    end
  endtask

  task automatic check_cell(input coarse_cell_t got);
    coarse_cell_t want;
    if (expected_cells.size() == 0) begin
      $display("%0t: unexpected coarse cell occ %0d row %0d col %0d last %0d", $time,
               got.occupied, got.row, got.col, got.last_cell);
      failures++;
      return;
    end
    want = expected_cells.pop_front();
    cells_checked++;
    if (got.occupied !== want.occupied) begin
      $display("%0t: coarse_occupied expected %0d got %0d", $time, want.occupied, got.occupied);
      failures++;
    end
    if (got.row !== want.row) begin
      $display("%0t: coarse_row expected %0d got %0d", $time, want.row, got.row);
      failures++;
    end
    if (got.col !== want.col) begin
      $display("%0t: coarse_col expected %0d got %0d", $time, want.col, got.col);
      failures++;
    end
    if (got.last_cell !== want.last_cell) begin
      $display("%0t: last_cell expected %0d got %0d", $time, want.last_cell, got.last_cell);
      failures++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output side: random stalls, one long hold, compare each accepted cell
  initial begin : output_side
    coarse_cell_t got;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && cells_checked >= HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= (!quiet && $urandom_range(99) < 6) ? 1'b0 : 1'b1;
      @(posedge clk);
      if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.coarse_occupied, out_ch.coarse_row, out_ch.coarse_col,
               out_ch.last_cell};
        check_cell(got);
      end
    end
  end

  initial begin : stimulus
    int unsigned bs;
    int unsigned max_side;
    int unsigned r;
    int phase;
    int random_start;
    logic [31:0] bs_word;
    logic [31:0] w_word;
    logic [31:0] h_word;
    int densities [7];

    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.occupied = 1'b0;
    out_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    densities      = '{0, 3, 30, 50, 70, 97, 100};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_plan = '{
      // after reset: block 1 on a 4096 x 4096 map, each cell passes straight through
      known_row(1, 0, 0, 0), known_row(0, 0, 1, 0), known_row(1, 0, 2, 0),
      known_row(0, 0, 3, 0),
      // shrink the map mid-row: the column counter is already past the new width
      reg_row(REG_FINE_WIDTH, 32'd4), reg_row(REG_FINE_HEIGHT, 32'd2),
      none_row(1),
      known_row(0, 1, 0, 0), known_row(1, 1, 1, 0), known_row(0, 1, 2, 0),
      known_row(1, 1, 3, 1),
      // 2x2 blocks on a 3x2 map: occupied cells in the right strip are dropped
      reg_row(REG_BLOCK_SIZE, 32'd2), reg_row(REG_FINE_WIDTH, 32'd3),
      cell_row(0), cell_row(0), cell_row(1), cell_row(0), cell_row(0), cell_row(1),
      // zero block and width clamp to one, an all-ones height word to 4096 rows
      reg_row(REG_BLOCK_SIZE, 32'd0), reg_row(REG_FINE_WIDTH, 32'd0),
      reg_row(REG_FINE_HEIGHT, 32'hFFFF_FFFF),
      known_row(1, 0, 0, 0), known_row(0, 1, 0, 0), known_row(1, 2, 0, 0),
      // oversized block on a tiny map: no coarse cell, counters still wrap
      reg_row(REG_BLOCK_SIZE, 32'd31), reg_row(REG_FINE_WIDTH, 32'd3),
      reg_row(REG_FINE_HEIGHT, 32'd2),
      none_row(1), none_row(0), none_row(1), none_row(1), none_row(1), none_row(0),
      none_row(0), none_row(1), none_row(1)
    };

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == PLAN_WRITE) begin
        settle();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].word);
      end else begin
        send_cell(directed_plan[i].occ, directed_plan[i].typed,
                  directed_plan[i].typed_emits, directed_plan[i].typed_cell);
      end
    end

    // tall single-column map with the long output hold, then the largest block unstalled
    run_phase(32'd1, 32'd1, 32'd4096, 400, 50, -1);
    quiet = 1'b1;
    run_phase(32'd16, 32'd17, 32'd16, 272, 1, -1);
    quiet = 1'b0;

    // random settings, mostly small blocks and maps
    random_start = cells_sent;
    phase = 0;
    while (cells_sent - random_start < 650) begin
      r = $urandom_range(99);
      if (r < 8) begin
        bs = 1;
        bs_word = 32'd0;
      end else if (r < 14) begin
        bs = 16;
        bs_word = 32'($urandom_range(17, 31));
      end else if (r < 75) begin
        bs = $urandom_range(1, 4);
        bs_word = 32'(bs);
      end else begin
        bs = $urandom_range(5, 16);
        bs_word = 32'(bs);
      end
      max_side = bs * ((bs <= 4) ? 6 : 2) + bs - 1;
      w_word = ($urandom_range(99) < 5) ? 32'd0 : 32'($urandom_range(1, max_side));
      r = $urandom_range(99);
      h_word = (r < 5) ? 32'd0 :
               (r < 9) ? 32'($urandom_range(4097, 8191)) : 32'($urandom_range(1, max_side));
      // junk above each field must be ignored
      bs_word |= $urandom() & 32'hFFFF_FFE0;
      w_word  |= $urandom() & 32'hFFFF_E000;
      h_word  |= $urandom() & 32'hFFFF_E000;
      run_phase(bs_word, w_word, h_word, $urandom_range(20, 120),
                densities[$urandom_range(6)], (phase == 0) ? 10 : -1);
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d fine cells sent, %0d coarse cells checked, %0d register writes",
             cells_sent, cells_checked, reg_writes);
    $display("Covered clamped block and map sizes, a tall single-column map, edge strips,");
    $display("mid-map register changes, random stalls and a long output hold");
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("%0t: timed out, %0d coarse cells still pending", $time, expected_cells.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ogd_pkg.sv
rtl/ogd_in_if.sv
rtl/ogd_out_if.sv
rtl/ogd_div.sv
rtl/occupancy_grid_block_or_downsampler.sv
dv/occupancy_grid_block_or_downsampler_tb.sv
